/* design/char_class_pattern_search_unit_assert.svh */
// Assertion macros for the pattern search unit checker
`ifndef CHAR_CLASS_PATTERN_SEARCH_UNIT_ASSERT_SVH
`define CHAR_CLASS_PATTERN_SEARCH_UNIT_ASSERT_SVH

// property checked outside reset
`define CCPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define CCPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* design/ccps_pkg.sv */
// ----------------------------------------------------------------------------
// ccps_pkg
// Shared types, constants and helpers of the character class pattern search.
// ----------------------------------------------------------------------------
package ccps_pkg;

    localparam int MaxPatBytes = 32;
    localparam int MaxTextBytes = 4096;
    localparam int PatBits = MaxPatBytes * 8;
    localparam int TokW = $clog2(MaxPatBytes);
    localparam int LenW = 6;
    localparam int PosW = 13;
    localparam int IdxW = 12;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgAddrW-1:0] REG_PAT0 = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_PAT1 = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_PAT2 = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_PAT3 = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_LEN  = 3'd4;

    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    typedef enum logic [2:0] {
        TK_SET,
        TK_NSET,
        TK_LOWER,
        TK_UPPER,
        TK_ALNUM
    } t_tok_kind;

    // mask marks the pattern byte positions a set or literal token compares against
    typedef struct packed {
        t_tok_kind              kind;
        logic [MaxPatBytes-1:0] mask;
    } t_token;

    typedef struct packed {
        logic [MaxPatBytes-1:0] mask;
        logic                   last;
    } t_qword;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_TOKEN,
        PS_SET_HEAD,
        PS_SET_BODY,
        PS_ESC
    } t_parse_state;

    function automatic logic [7:0] pat_byte(logic [PatBits-1:0] pat, logic [TokW-1:0] i);
        return pat[i*8 +: 8];
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return is_lower(c) || is_upper(c) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

endpackage

/* design/ccps_tok_parser.sv */
// ----------------------------------------------------------------------------
// ccps_tok_parser
// Walks the raw pattern one byte a cycle, pausing at set heads without a caret, and builds the token table.
// ----------------------------------------------------------------------------
module ccps_tok_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ccps_pkg::PatBits-1:0]      i_pat,
    input  logic [ccps_pkg::LenW-1:0]         i_len,
    output logic                              o_busy,
    output ccps_pkg::t_token [ccps_pkg::MaxPatBytes-1:0] o_tokens,
    output logic [ccps_pkg::LenW-1:0]         o_tok_cnt
);

    ccps_pkg::t_parse_state r_state, n_state;
    logic [ccps_pkg::LenW-1:0]        r_i, n_i;
    logic [ccps_pkg::LenW-1:0]        r_t, n_t;
    logic [ccps_pkg::MaxPatBytes-1:0] r_acc, n_acc;
    logic                             r_neg, n_neg;
    ccps_pkg::t_token [ccps_pkg::MaxPatBytes-1:0] r_tok;

    logic [ccps_pkg::LenW-1:0]        w_len;
    logic                             w_in;
    logic                             w_esc_ok;
    logic [7:0]                       w_b;
    logic [ccps_pkg::MaxPatBytes-1:0] w_bit;
    logic                             w_we;
    ccps_pkg::t_token                 w_wtok;

    assign w_len    = (i_len > ccps_pkg::LenW'(ccps_pkg::MaxPatBytes))
                    ? ccps_pkg::LenW'(ccps_pkg::MaxPatBytes) : i_len;
    assign w_in     = r_i < w_len;
    assign w_esc_ok = (r_i + ccps_pkg::LenW'(1)) < w_len;
    assign w_b      = ccps_pkg::pat_byte(i_pat, r_i[ccps_pkg::TokW-1:0]);
    assign w_bit    = ccps_pkg::MaxPatBytes'(1) << r_i[ccps_pkg::TokW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = ccps_pkg::PS_TOKEN;
        end else begin
            unique case (r_state)
                ccps_pkg::PS_IDLE: n_state = ccps_pkg::PS_IDLE;
                ccps_pkg::PS_TOKEN: begin
                    if (!w_in || r_t == ccps_pkg::LenW'(ccps_pkg::MaxPatBytes))
                        n_state = ccps_pkg::PS_IDLE;
                    else if (w_b == ccps_pkg::CH_LBRACK)
                        n_state = ccps_pkg::PS_SET_HEAD;
                    else if (w_b == ccps_pkg::CH_BSLASH && w_esc_ok)
                        n_state = ccps_pkg::PS_ESC;
                end
                ccps_pkg::PS_SET_HEAD:
                    n_state = w_in ? ccps_pkg::PS_SET_BODY : ccps_pkg::PS_TOKEN;
                ccps_pkg::PS_SET_BODY: begin
                    if (!w_in || w_b == ccps_pkg::CH_RBRACK)
                        n_state = ccps_pkg::PS_TOKEN;
                end
                ccps_pkg::PS_ESC: n_state = ccps_pkg::PS_TOKEN;
                default: n_state = ccps_pkg::PS_IDLE;
            endcase
        end
    end

    // datapath and table writes
    always_comb begin
        n_i         = r_i;
        n_t         = r_t;
        n_acc       = r_acc;
        n_neg       = r_neg;
        w_we        = 1'b0;
        w_wtok.kind = ccps_pkg::TK_SET;
        w_wtok.mask = w_bit;
        if (i_start) begin
            n_i   = '0;
            n_t   = '0;
            n_acc = '0;
            n_neg = 1'b0;
        end else begin
            unique case (r_state)
                ccps_pkg::PS_TOKEN: begin
                    if (w_in && r_t != ccps_pkg::LenW'(ccps_pkg::MaxPatBytes)) begin
                        n_i = r_i + ccps_pkg::LenW'(1);
                        if (w_b == ccps_pkg::CH_LBRACK) begin
                            n_acc = '0;
                            n_neg = 1'b0;
                        end else if (w_b == ccps_pkg::CH_BSLASH && w_esc_ok) begin
                            n_acc = r_acc;
                        end else begin
                            w_we = 1'b1;
                            if (w_b == ccps_pkg::CH_DOT)
                                w_wtok.kind = ccps_pkg::TK_ALNUM;
                        end
                    end
                end
                ccps_pkg::PS_SET_HEAD: begin
                    if (!w_in) begin
                        w_we        = 1'b1;
                        w_wtok.mask = '0;
                    end else if (w_b == ccps_pkg::CH_CARET) begin
                        n_neg = 1'b1;
                        n_i   = r_i + ccps_pkg::LenW'(1);
                    end
                end
                ccps_pkg::PS_SET_BODY: begin
                    if (!w_in || w_b == ccps_pkg::CH_RBRACK) begin
                        w_we        = 1'b1;
                        w_wtok.kind = r_neg ? ccps_pkg::TK_NSET : ccps_pkg::TK_SET;
                        w_wtok.mask = r_acc;
                        if (w_in)
                            n_i = r_i + ccps_pkg::LenW'(1);
                    end else begin
                        n_acc = r_acc | w_bit;
                        n_i   = r_i + ccps_pkg::LenW'(1);
                    end
                end
                ccps_pkg::PS_ESC: begin
                    w_we = 1'b1;
                    n_i  = r_i + ccps_pkg::LenW'(1);
                    if (w_b == ccps_pkg::CH_LOWER_A)
                        w_wtok.kind = ccps_pkg::TK_LOWER;
                    else if (w_b == ccps_pkg::CH_UPPER_A)
                        w_wtok.kind = ccps_pkg::TK_UPPER;
                end
                default: n_i = r_i;
            endcase
            if (w_we)
                n_t = r_t + ccps_pkg::LenW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccps_pkg::PS_IDLE;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_acc <= n_acc;
        r_neg <= n_neg;
        if (w_we)
            r_tok[r_t[ccps_pkg::TokW-1:0]] <= w_wtok;
    end

    assign o_busy    = r_state != ccps_pkg::PS_IDLE;
    assign o_tokens  = r_tok;
    assign o_tok_cnt = r_t;

endmodule

/* design/ccps_front.sv */
// ----------------------------------------------------------------------------
// ccps_front
// Accepts text words and turns each byte into a per-token match mask.
// ----------------------------------------------------------------------------
module ccps_front (
    input  logic                              i_valid,
    input  logic [7:0]                        i_byte,
    input  logic                              i_last,
    input  logic                              i_hold,
    input  logic                              i_q_full,
    input  logic [ccps_pkg::PatBits-1:0]      i_pat,
    input  ccps_pkg::t_token [ccps_pkg::MaxPatBytes-1:0] i_tokens,
    output logic                              o_ready,
    output logic                              o_push,
    output ccps_pkg::t_qword                  o_word
);

    logic [ccps_pkg::MaxPatBytes-1:0] w_eq;
    logic [ccps_pkg::MaxPatBytes-1:0] w_ok;

    always_comb begin
        for (int j = 0; j < ccps_pkg::MaxPatBytes; j++)
            w_eq[j] = ccps_pkg::pat_byte(i_pat, ccps_pkg::TokW'(j)) == i_byte;
    end

    always_comb begin
        for (int t = 0; t < ccps_pkg::MaxPatBytes; t++) begin
            unique case (i_tokens[t].kind)
                ccps_pkg::TK_SET:   w_ok[t] = |(w_eq & i_tokens[t].mask);
                ccps_pkg::TK_NSET:  w_ok[t] = ~|(w_eq & i_tokens[t].mask);
                ccps_pkg::TK_LOWER: w_ok[t] = ccps_pkg::is_lower(i_byte);
                ccps_pkg::TK_UPPER: w_ok[t] = ccps_pkg::is_upper(i_byte);
                ccps_pkg::TK_ALNUM: w_ok[t] = ccps_pkg::is_alnum(i_byte);
                default:            w_ok[t] = 1'b0;
            endcase
        end
    end

    assign o_ready     = !i_hold && !i_q_full;
    assign o_push      = i_valid && o_ready;
    assign o_word.mask = w_ok;
    assign o_word.last = i_last;

endmodule

/* design/ccps_queue.sv */
// ----------------------------------------------------------------------------
// ccps_queue
// Two-entry queue between classifier and matcher.
// ----------------------------------------------------------------------------
module ccps_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ccps_pkg::t_qword  i_word,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output ccps_pkg::t_qword  o_word
);

    ccps_pkg::t_qword r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= !r_wp;
            if (i_pop)
                r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_word;
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_word  = r_mem[r_rp];

endmodule

/* design/ccps_back.sv */
// ----------------------------------------------------------------------------
// ccps_back
// Shift-and matcher, position count and result register.
// ----------------------------------------------------------------------------
module ccps_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  ccps_pkg::t_qword              i_word,
    input  logic [ccps_pkg::LenW-1:0]     i_tok_cnt,
    input  logic                          i_ready,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [ccps_pkg::IdxW-1:0]     o_start
);

    logic [ccps_pkg::MaxPatBytes-1:0] r_vec, n_vec;
    logic [ccps_pkg::PosW-1:0]        r_pos, n_pos;
    logic                             r_seen, n_seen;
    logic [ccps_pkg::IdxW-1:0]        r_first, n_first;
    logic                             r_o_valid, n_o_valid;
    logic                             r_o_found, n_o_found;
    logic [ccps_pkg::IdxW-1:0]        r_o_start, n_o_start;

    logic                             w_live;
    logic [ccps_pkg::TokW-1:0]        w_top;
    logic [ccps_pkg::MaxPatBytes-1:0] w_vec;
    logic [ccps_pkg::PosW-1:0]        w_sum;

    assign o_pop  = i_q_valid && (!r_o_valid || i_ready);
    assign w_live = r_pos < ccps_pkg::PosW'(ccps_pkg::MaxTextBytes);
    assign w_top  = ccps_pkg::TokW'(i_tok_cnt - ccps_pkg::LenW'(1));
    assign w_vec  = ((r_vec << 1) | ccps_pkg::MaxPatBytes'(1)) & i_word.mask;
    assign w_sum  = r_pos + ccps_pkg::PosW'(1) - ccps_pkg::PosW'(i_tok_cnt);

    always_comb begin
        n_vec     = r_vec;
        n_pos     = r_pos;
        n_seen    = r_seen;
        n_first   = r_first;
        n_o_valid = r_o_valid && !i_ready;
        n_o_found = r_o_found;
        n_o_start = r_o_start;
        if (o_pop) begin
            if (i_tok_cnt == '0) begin
                if (!r_seen) begin
                    n_seen  = 1'b1;
                    n_first = '0;
                end
            end else if (w_live) begin
                n_vec = w_vec;
                if (!r_seen && w_vec[w_top]) begin
                    n_seen  = 1'b1;
                    n_first = w_sum[ccps_pkg::IdxW-1:0];
                end
            end
            if (w_live)
                n_pos = r_pos + ccps_pkg::PosW'(1);
            if (i_word.last) begin
                n_o_valid = 1'b1;
                n_o_found = n_seen;
                n_o_start = n_seen ? n_first : '0;
                n_vec     = '0;
                n_pos     = '0;
                n_seen    = 1'b0;
                n_first   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec     <= '0;
            r_pos     <= '0;
            r_seen    <= 1'b0;
            r_first   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_vec     <= n_vec;
            r_pos     <= n_pos;
            r_seen    <= n_seen;
            r_first   <= n_first;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_found <= n_o_found;
        r_o_start <= n_o_start;
    end

    assign o_valid = r_o_valid;
    assign o_found = r_o_found;
    assign o_start = r_o_start;

endmodule

/* design/char_class_pattern_search_unit.sv */
// ----------------------------------------------------------------------------
// char_class_pattern_search_unit
// Finds the first match of a character class pattern in a byte stream.
// ----------------------------------------------------------------------------
// Slave stream: one text byte per word in tdata, tlast marks the final byte.
// Master stream: one word per text, sent for the byte marked tlast;
//   tuser = found, tdata = start index of the first match (0 if none).
// Config port: registers 0..3 hold pattern bytes 0..31 (lowest byte first),
//   register 4 the pattern length. Write only while the block is idle.
// Each write restarts the pattern parser, which walks one pattern byte per
//   cycle and pauses at each set head without a caret: o_s_tready is low
//   during the write and while the parser is busy after the last write.
// Throughput: one byte per cycle while the parser is idle and the master side does not stall.
// The result word is registered: the tlast byte goes through a queue entry, then the result register.
// Reset clears the pattern to empty, the match state and the output valid flag (not found or start).
// A stalled master side holds the result; the 2-entry queue absorbs up to
//   2 more bytes before o_s_tready drops.
// ----------------------------------------------------------------------------
module char_class_pattern_search_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] text_byte
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [15:0]                     o_m_tdata,   // [11:0] start_index, zero fill
    output logic                            o_m_tuser,   // [0] found
    input  logic                            i_cfg_we,
    input  logic [ccps_pkg::CfgAddrW-1:0]   i_cfg_addr,
    input  logic [ccps_pkg::CfgDataW-1:0]   i_cfg_wdata
);

    logic [ccps_pkg::PatBits-1:0] r_pat;
    logic [ccps_pkg::LenW-1:0]    r_len;

    ccps_pkg::t_token [ccps_pkg::MaxPatBytes-1:0] w_tokens;
    logic [ccps_pkg::LenW-1:0]    w_tok_cnt;
    logic                         w_busy;
    logic                         w_push, w_pop, w_full, w_q_valid;
    ccps_pkg::t_qword             w_in_word, w_q_word;
    logic [ccps_pkg::IdxW-1:0]    w_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ccps_pkg::REG_PAT0: r_pat[0*ccps_pkg::CfgDataW +: ccps_pkg::CfgDataW] <= i_cfg_wdata;
                ccps_pkg::REG_PAT1: r_pat[1*ccps_pkg::CfgDataW +: ccps_pkg::CfgDataW] <= i_cfg_wdata;
                ccps_pkg::REG_PAT2: r_pat[2*ccps_pkg::CfgDataW +: ccps_pkg::CfgDataW] <= i_cfg_wdata;
                ccps_pkg::REG_PAT3: r_pat[3*ccps_pkg::CfgDataW +: ccps_pkg::CfgDataW] <= i_cfg_wdata;
                ccps_pkg::REG_LEN:  r_len <= i_cfg_wdata[ccps_pkg::LenW-1:0];
                default:            r_len <= r_len;
            endcase
        end
    end

    ccps_tok_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cfg_we),
        .i_pat     (r_pat),
        .i_len     (r_len),
        .o_busy    (w_busy),
        .o_tokens  (w_tokens),
        .o_tok_cnt (w_tok_cnt)
    );

    ccps_front u_front (
        .i_valid  (i_s_tvalid),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_hold   (w_busy || i_cfg_we),
        .i_q_full (w_full),
        .i_pat    (r_pat),
        .i_tokens (w_tokens),
        .o_ready  (o_s_tready),
        .o_push   (w_push),
        .o_word   (w_in_word)
    );

    ccps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_in_word),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_word  (w_q_word)
    );

    ccps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_word    (w_q_word),
        .i_tok_cnt (w_tok_cnt),
        .i_ready   (i_m_tready),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .o_found   (o_m_tuser),
        .o_start   (w_start)
    );

    assign o_m_tdata = 16'(w_start);

endmodule

/* design/ccps_checker.sv */
// ----------------------------------------------------------------------------
// ccps_checker
// Port-level checks of the pattern search unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_class_pattern_search_unit_assert.svh"

module ccps_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [15:0]                   o_m_tdata,
    input logic                          o_m_tuser,
    input logic                          i_cfg_we
);

    `CCPS_ASSERT(a_hold_result, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")
    `CCPS_ASSERT(a_miss_zero, o_m_tvalid && !o_m_tuser |-> o_m_tdata == 16'd0, "start index nonzero without match")
    `CCPS_ASSERT(a_index_range, o_m_tvalid |-> o_m_tdata[15:12] == 4'd0, "start index padding not zero")
    `CCPS_ASSERT(a_cfg_blocks_input, i_cfg_we |-> !o_s_tready ##1 !o_s_tready, "input taken during pattern load")
    `CCPS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind char_class_pattern_search_unit ccps_checker u_ccps_checker (.*);
